[sv/itr_pkg.sv]
// shared types and constants for integer_to_text_radix
// no dependencies; imported by the divider and the top level
`default_nettype none

package itr_pkg;

   // field widths
   localparam int VALUE_W = 32;
   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 8;

   // digit buffer sizing
   localparam int MAX_DIGITS = 32;
   localparam int ADDR_W     = $clog2(MAX_DIGITS);
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int STEP_W     = $clog2(VALUE_W);

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   // special radix codes
   localparam logic [RADIX_W-1:0] RADIX_RAW     = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_INVALID = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // digit to ascii: 0-9 then letters
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
      if (d < RADIX_DEC) begin
         return CHAR_ZERO + dx;
      end
      return CHAR_UPPER + dx - {{(CHAR_W-RADIX_W){1'b0}}, RADIX_DEC};
   endfunction

endpackage

`default_nettype wire

[sv/integer_to_text_radix.sv]
// Converts one value to ASCII text, one character per rsp item, most significant first.
// Each digit takes one division on the serial divider, and each emitted character waits for
// rsp_ready; up to 32 binary digits, plus a sign and CR LF; req_ready only in idle.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
// Depends on itr_pkg, itr_divider and itr_ram.
`default_nettype none

module integer_to_text_radix (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [itr_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                          req_signed_value,
   input  wire logic [itr_pkg::RADIX_W-1:0]   req_base,
   input  wire logic                          req_add_newline,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [itr_pkg::CHAR_W-1:0]    rsp_character,
   output logic                               rsp_last,
   output logic                               rsp_bad_base
);

   import itr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV,
      S_READ,
      S_DIGIT,
      S_CR,
      S_LF,
      S_SEND
   } state_type;

   state_type          state_ff, ret_ff;
   logic [VALUE_W-1:0] num_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic               nl_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               out_valid_ff;
   logic [CHAR_W-1:0]  out_char_ff;
   logic               out_last_ff;
   logic               out_bad_ff;

   logic               div_start;
   logic [VALUE_W-1:0] div_quot;
   logic [RADIX_W-1:0] div_rem;
   div_status_type     div_sts;
   logic               ram_wr;
   logic               ram_rd;
   logic [RADIX_W-1:0] ram_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [CNT_W-1:0]   cnt_dec;
   logic               negative;
   logic [VALUE_W-1:0] magnitude;

   // serial divider
   itr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff),
      .divisor   (radix_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .status    (div_sts)
   );

   // digit buffer, least significant digit at address zero
   itr_ram #(
      .WIDTH (RADIX_W),
      .DEPTH (MAX_DIGITS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (div_rem),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // sequencer strobes
   always_comb begin
      cnt_dec   = cnt_ff - CNT_W'(1);
      rd_addr   = cnt_dec[ADDR_W-1:0];
      div_start = (state_ff == S_DIV_GO) && (num_ff != '0) &&
                  (cnt_ff != CNT_W'(MAX_DIGITS));
      ram_wr    = (state_ff == S_DIV) && div_sts.done;
      ram_rd    = (state_ff == S_READ);
      negative  = (req_base == RADIX_DEC) && req_signed_value && req_value[VALUE_W-1];
      magnitude = negative ? (VALUE_W'(0) - req_value) : req_value;
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  radix_ff <= req_base;
                  nl_ff    <= req_add_newline;
                  num_ff   <= magnitude;
                  cnt_ff   <= '0;
                  if (req_base == RADIX_INVALID) begin
                     out_char_ff  <= CHAR_NUL;
                     out_last_ff  <= 1'b1;
                     out_bad_ff   <= 1'b1;
                     out_valid_ff <= 1'b1;
                     ret_ff       <= S_IDLE;
                     state_ff     <= S_SEND;
                  end else if (req_base == RADIX_RAW) begin
                     out_char_ff  <= req_value[CHAR_W-1:0];
                     out_last_ff  <= !req_add_newline;
                     out_bad_ff   <= 1'b0;
                     out_valid_ff <= 1'b1;
                     ret_ff       <= req_add_newline ? S_CR : S_IDLE;
                     state_ff     <= S_SEND;
                  end else if (negative) begin
                     out_char_ff  <= CHAR_MINUS;
                     out_last_ff  <= 1'b0;
                     out_bad_ff   <= 1'b0;
                     out_valid_ff <= 1'b1;
                     ret_ff       <= S_DIV_GO;
                     state_ff     <= S_SEND;
                  end else begin
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            S_DIV_GO: begin
               if (num_ff == '0 && cnt_ff == '0) begin
                  // zero value prints one zero digit
                  out_char_ff  <= CHAR_ZERO;
                  out_last_ff  <= !nl_ff;
                  out_bad_ff   <= 1'b0;
                  out_valid_ff <= 1'b1;
                  ret_ff       <= nl_ff ? S_CR : S_IDLE;
                  state_ff     <= S_SEND;
               end else if (div_start) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_DIV: begin
               if (div_sts.done) begin
                  num_ff   <= div_quot;
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= S_DIV_GO;
               end
            end
            S_READ: begin
               cnt_ff   <= cnt_dec;
               state_ff <= S_DIGIT;
            end
            S_DIGIT: begin
               out_char_ff  <= digit_char(ram_data);
               out_last_ff  <= (cnt_ff == '0) && !nl_ff;
               out_bad_ff   <= 1'b0;
               out_valid_ff <= 1'b1;
               ret_ff       <= (cnt_ff != '0) ? S_READ : (nl_ff ? S_CR : S_IDLE);
               state_ff     <= S_SEND;
            end
            S_CR: begin
               out_char_ff  <= CHAR_CR;
               out_last_ff  <= 1'b0;
               out_bad_ff   <= 1'b0;
               out_valid_ff <= 1'b1;
               ret_ff       <= S_LF;
               state_ff     <= S_SEND;
            end
            S_LF: begin
               out_char_ff  <= CHAR_LF;
               out_last_ff  <= 1'b1;
               out_bad_ff   <= 1'b0;
               out_valid_ff <= 1'b1;
               ret_ff       <= S_IDLE;
               state_ff     <= S_SEND;
            end
            S_SEND: begin
               if (rsp_ready) begin
                  out_valid_ff <= 1'b0;
                  state_ff     <= ret_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_bad_base  = out_bad_ff;

   // an output item is valid only while waiting for the consumer
   a_valid_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_SEND)
      else $error("rsp item pending outside send state");

   // no new item is taken while a character is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req accepted while rsp pending");

   // a rejected base is a single terminal nul item
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_base |-> rsp_last && rsp_character == CHAR_NUL)
      else $error("bad base item malformed");

   // the divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == S_DIV)
      else $error("divider done outside divide state");

   // the divider runs only while the sequencer waits on it
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == S_DIV)
      else $error("divider busy outside divide state");

   // digit count stays within the buffer
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count overflow");

endmodule

`default_nettype wire

[sv/itr_ram.sv]
// generic single write port ram with registered read
// no dependencies; holds the digit buffer
`default_nettype none

module itr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/itr_divider.sv]
// bit-serial restoring divider: 32-bit dividend by 6-bit radix
// depends on itr_pkg; one quotient bit per cycle
`default_nettype none

module itr_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [itr_pkg::VALUE_W-1:0]   dividend,
   input  wire logic [itr_pkg::RADIX_W-1:0]   divisor,
   output logic      [itr_pkg::VALUE_W-1:0]   quotient,
   output logic      [itr_pkg::RADIX_W-1:0]   remainder,
   output itr_pkg::div_status_type            status
);

   import itr_pkg::*;

   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] dvs_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff, done_ff;
   logic [RADIX_W:0]   trial;
   logic [RADIX_W:0]   diff;
   logic               fits;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, quot_ff[VALUE_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      quot_in = {quot_ff[VALUE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            quot_ff <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quot_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire
